### rtl/fbm_pkg.sv
// Package for the FSK byte modulator: command and register codes, framing
// constants and the words that travel between the front, back and queues.
// No dependencies.
`default_nettype none

package fbm_pkg;

	// input commands
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SEND  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// configuration register indexes
	localparam logic [3:0] REG_TABLE_LENGTH = 4'd0;
	localparam logic [3:0] REG_MARK_STEP    = 4'd1;
	localparam logic [3:0] REG_SPACE_STEP   = 4'd2;
	localparam logic [3:0] REG_BIT_LEN      = 4'd3;

	// start bit, eight data bits, stop bit
	localparam int FRAME_BITS = 10;

	// depth of the queues between front, back and result port
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [0:0] {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef struct packed {
		logic [10:0] table_length;
		logic [9:0]  mark_step;
		logic [9:0]  space_step;
		logic [15:0] bit_len;
	} cfg_t;

	// work handed from the front to the back
	typedef struct packed {
		op_t         op;
		logic        level;
		logic        last;
		logic [31:0] number;
		logic [9:0]  tbl_index;
		logic [11:0] tbl_value;
	} mid_word_t;

	typedef struct packed {
		logic [11:0] sample;
		logic [31:0] number;
		logic        level;
		logic        last;
	} result_word_t;

endpackage

`default_nettype wire

### rtl/fbm_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
// Generic payload width; no package dependencies.
`default_nettype none

module fbm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

### rtl/fbm_front.sv
// Front end: accepts input words, keeps the UART framing state and the
// sample count, and hands ticks and table writes to the back. Uses fbm_pkg.
`default_nettype none

module fbm_front
	import fbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  data_byte,
	input  wire logic [9:0]  table_index,
	input  wire logic [11:0] table_value,
	input  wire logic        mid_full,
	output logic             mid_push,
	output mid_word_t        mid_word
);

	logic                  busy_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [3:0]            bitpos_q;
	logic [15:0]           sib_q;
	logic [31:0]           count_q;

	logic accept;
	logic level;
	logic end_of_bit;
	logic last;

	assign full   = mid_full;
	assign accept = push && !mid_full;

	assign level      = frame_q[bitpos_q];
	assign end_of_bit = ({1'b0, sib_q} + 17'd1) >= {1'b0, cfg.bit_len};
	assign last       = end_of_bit && (bitpos_q >= 4'(FRAME_BITS - 1));

	// only ticks during a frame and table writes reach the back
	assign mid_push = accept && ((cmd == CMD_WRITE) || ((cmd == CMD_TICK) && busy_q));

	always_comb begin
		mid_word.op        = (cmd == CMD_WRITE) ? OP_WRITE : OP_TICK;
		mid_word.level     = level;
		mid_word.last      = last;
		mid_word.number    = count_q + 32'd1;
		mid_word.tbl_index = table_index;
		mid_word.tbl_value = table_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			bitpos_q <= '0;
			sib_q    <= '0;
			count_q  <= '0;
		end else if (accept) begin
			case (cmd)
				CMD_SEND: begin
					if (!busy_q) begin
						bitpos_q <= '0;
						sib_q    <= '0;
						busy_q   <= 1'b1;
					end
				end
				CMD_TICK: begin
					if (busy_q) begin
						count_q <= count_q + 32'd1;
						if (end_of_bit) begin
							sib_q <= '0;
							if (last) begin
								busy_q   <= 1'b0;
								bitpos_q <= '0;
							end else begin
								bitpos_q <= bitpos_q + 4'd1;
							end
						end else begin
							sib_q <= sib_q + 16'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// frame: stop bit (mark), data MSB..LSB, start bit (space)
	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_SEND) && !busy_q) frame_q <= {1'b1, data_byte, 1'b0};
	end

endmodule

`default_nettype wire

### rtl/fbm_back.sv
// Back end: phase accumulator and sine table. Writes table entries and
// turns each tick into a registered sample word. Uses fbm_pkg.
`default_nettype none

module fbm_back
	import fbm_pkg::*;
#(
	parameter int TABLE_SIZE = 1024,
	parameter int DAC_BITS   = 12
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      head_valid,
	input  wire mid_word_t head,
	output logic           head_pop,
	output logic           res_valid,
	output result_word_t   res_word,
	input  wire logic      res_ready
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int PW = (AW < 11) ? AW : 11;
	localparam logic [10:0] LEN_RESET = 11'((TABLE_SIZE < 1024) ? TABLE_SIZE : 1024);

	logic [DAC_BITS-1:0] mem_q [TABLE_SIZE];
	logic [PW-1:0]       phase_q;

	// phase reduction after a length change
	logic [10:0]         len_seen_q;
	logic                red_busy_q;
	logic [3:0]          red_sh_q;

	logic                valid_s1;
	logic [DAC_BITS-1:0] sample_s1;
	logic [31:0]         number_s1;
	logic                level_s1;
	logic                last_s1;

	logic          go;
	logic          tick_go;
	logic          wr_en;
	logic          red_hold;
	logic          red_sub_en;
	logic [21:0]   red_sub;
	logic [9:0]    step;
	logic [11:0]   sum;
	logic [11:0]   wrapped;
	logic [PW-1:0] phase_next;

	// hold ticks until the phase sits below the current length
	assign red_hold   = red_busy_q || (len_seen_q != cfg.table_length);
	assign red_sub    = {11'd0, len_seen_q} << red_sh_q;
	assign red_sub_en = red_busy_q && (len_seen_q == cfg.table_length)
		&& (22'(phase_q) >= red_sub);

	// a write never waits on the result side; a tick needs the sample stage free
	assign go       = head_valid && ((head.op == OP_WRITE)
		|| (!red_hold && (!valid_s1 || res_ready)));
	assign head_pop = go;
	assign tick_go  = go && (head.op == OP_TICK);
	assign wr_en    = go && (head.op == OP_WRITE) && (32'(head.tbl_index) < TABLE_SIZE);

	// phase and step both stay below table_length, so one subtract wraps
	assign step       = head.level ? cfg.mark_step : cfg.space_step;
	assign sum        = 12'(phase_q) + 12'(step);
	assign wrapped    = (sum >= 12'(cfg.table_length)) ? sum - 12'(cfg.table_length) : sum;
	assign phase_next = PW'(wrapped);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (tick_go) begin
				phase_q <= phase_next;
			end else if (red_sub_en) begin
				phase_q <= phase_q - PW'(red_sub);
			end
			if (tick_go) begin
				valid_s1 <= 1'b1;
			end else if (res_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// long-division remainder: one compare and subtract per cycle, top bit first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_seen_q <= LEN_RESET;
			red_busy_q <= 1'b0;
			red_sh_q   <= '0;
		end else if (len_seen_q != cfg.table_length) begin
			len_seen_q <= cfg.table_length;
			red_busy_q <= 1'b1;
			red_sh_q   <= 4'(PW - 1);
		end else if (red_busy_q) begin
			if (red_sh_q == '0) begin
				red_busy_q <= 1'b0;
			end else begin
				red_sh_q <= red_sh_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			number_s1 <= head.number;
			level_s1  <= head.level;
			last_s1   <= head.last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)   mem_q[AW'(head.tbl_index)] <= DAC_BITS'(head.tbl_value);
		if (tick_go) sample_s1 <= mem_q[AW'(phase_next)];
	end

	assign res_valid = valid_s1;

	always_comb begin
		res_word.sample = 12'(sample_s1);
		res_word.number = number_s1;
		res_word.level  = level_s1;
		res_word.last   = last_s1;
	end

endmodule

`default_nettype wire

### rtl/fsk_byte_modulator.sv
// FSK byte modulator, top level: configuration registers, front end,
// work queue, back end and result queue. Uses fbm_pkg, fbm_fifo,
// fbm_front and fbm_back.
//
// Input words (push/full) carry a sample tick, a byte to send or a sine
// table write. A byte sent while idle starts a ten-bit frame (start, eight
// data bits LSB first, stop); bytes sent during a frame are dropped. Each
// tick during a frame yields one result word (empty/pop): DAC code, running
// sample number, bit level and a flag on the last sample of the stop bit.
// Ticks while idle yield nothing. Table writes are taken at any time, in
// order with the ticks. Configuration writes (cfg_valid/cfg_ready, always
// ready) must go in only while nothing is in flight; the block does not
// enforce this. Out-of-range values are clamped. Throughput: one input
// word and one result word per cycle while neither side stalls. A tick's
// result passes the table read register, then the result queue. After a
// table_length write the back holds ticks while it brings the phase below
// the new length; the work queue absorbs four ticks, then full rises.
// Reset: framing idle, phase and sample count zero, registers at reset values.
// Stall: when pop holds low the result queue fills, the back holds, the work
// queue fills and full rises; nothing is lost.
`default_nettype none

module fsk_byte_modulator
	import fbm_pkg::*;
#(
	parameter int TABLE_SIZE = 1024,
	parameter int DAC_BITS   = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// input words
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  data_byte,
	input  wire logic [9:0]  table_index,
	input  wire logic [11:0] table_value,
	// result words
	output logic             empty,
	input  wire logic        pop,
	output logic [11:0]      sample,
	output logic [31:0]      sample_number,
	output logic             bit_level,
	output logic             frame_last
);

	localparam logic [10:0] LEN_RESET = 11'((TABLE_SIZE < 1024) ? TABLE_SIZE : 1024);

	cfg_t cfg_q;

	logic         cfg_we;
	logic [10:0]  len_new;

	logic         mid_push;
	logic         mid_full;
	logic         mid_empty;
	logic         mid_pop;
	mid_word_t    mid_in;
	logic [$bits(mid_word_t)-1:0] mid_rdata;
	mid_word_t    mid_head;

	logic         res_valid;
	logic         res_full;
	result_word_t res_word;
	logic [$bits(result_word_t)-1:0] res_rdata;
	result_word_t res_head;

	// clamp a phase step below the table length
	function automatic logic [9:0] clamp_step(input logic [9:0] s, input logic [10:0] len);
		return ({1'b0, s} >= len) ? 10'(len - 11'd1) : s;
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// table length limited to 1..TABLE_SIZE
	always_comb begin
		len_new = cfg_data[10:0];
		if (len_new == 11'd0) len_new = 11'd1;
		if (32'(len_new) > TABLE_SIZE) len_new = 11'(TABLE_SIZE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.table_length <= LEN_RESET;
			cfg_q.mark_step    <= '0;
			cfg_q.space_step   <= '0;
			cfg_q.bit_len      <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TABLE_LENGTH: begin
					// shrink the stored steps along with the length
					cfg_q.table_length <= len_new;
					cfg_q.mark_step    <= clamp_step(cfg_q.mark_step, len_new);
					cfg_q.space_step   <= clamp_step(cfg_q.space_step, len_new);
				end
				REG_MARK_STEP: begin
					cfg_q.mark_step <= clamp_step(cfg_data[9:0], cfg_q.table_length);
				end
				REG_SPACE_STEP: begin
					cfg_q.space_step <= clamp_step(cfg_data[9:0], cfg_q.table_length);
				end
				REG_BIT_LEN: begin
					// zero samples per bit means one
					cfg_q.bit_len <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// front: framing state and sample numbering
	fbm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.table_index (table_index),
		.table_value (table_value),
		.mid_full    (mid_full),
		.mid_push    (mid_push),
		.mid_word    (mid_in)
	);

	// work queue: lets the front keep taking words while the back stalls
	fbm_fifo #(
		.WIDTH ($bits(mid_word_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign mid_head = mid_word_t'(mid_rdata);

	// back: phase accumulator and sine table
	fbm_back #(
		.TABLE_SIZE (TABLE_SIZE),
		.DAC_BITS   (DAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (!mid_empty),
		.head       (mid_head),
		.head_pop   (mid_pop),
		.res_valid  (res_valid),
		.res_word   (res_word),
		.res_ready  (!res_full)
	);

	// result queue: holds finished samples while the receiver stalls
	fbm_fifo #(
		.WIDTH ($bits(result_word_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res_word),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_head      = result_word_t'(res_rdata);
	assign sample        = res_head.sample;
	assign sample_number = res_head.number;
	assign bit_level     = res_head.level;
	assign frame_last    = res_head.last;

endmodule

`default_nettype wire
